// ===== design/charge_slot_priority_scheduler_core_defines.svh =====
// assertion macros for the charge slot scheduler
// used by the controller file
`ifndef CHARGE_SLOT_PRIORITY_SCHEDULER_CORE_DEFINES_SVH
`define CHARGE_SLOT_PRIORITY_SCHEDULER_CORE_DEFINES_SVH
// implication checked on every clock edge out of reset
`define CSPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CSPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== design/csps_pkg.sv =====
// shared types and constants for the charge slot scheduler
// no dependencies
package csps_pkg;
	localparam int NUM_CHANNELS_DEF = 8;
	localparam int HARD_FIRST_WEIGHT = 220;
	localparam int HARD_LATER_WEIGHT = 1;
	localparam int MAX_ACTIVE_RESET = 2;

	localparam logic [2:0] CMD_UPDATE  = 3'd0;
	localparam logic [2:0] CMD_ON      = 3'd1;
	localparam logic [2:0] CMD_OFF     = 3'd2;
	localparam logic [2:0] CMD_HANGUP  = 3'd3;
	localparam logic [2:0] CMD_RECOVER = 3'd4;
	localparam logic [2:0] CMD_HANGALL = 3'd5;
	localparam logic [2:0] CMD_PASS    = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT,
		ST_COUNT,
		ST_ENABLE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic exec;
		logic sort_step;
		logic sort_start;
		logic count;
		logic en_start;
		logic en_step;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		logic is_pass;
		logic sort_done;
		logic en_done;
	} stat_t;
endpackage

// ===== design/csps_ctrl.sv =====
// controller state machine for the charge slot scheduler
// depends on csps_pkg and the defines header
`include "charge_slot_priority_scheduler_core_defines.svh"
module csps_ctrl
	import csps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  stat_t   st,
	output ctrl_t   ctl
);
	state_t state_q, state_d;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = st.is_pass ? ST_SORT : ST_OUT;
			end
			ST_SORT: begin
				if (st.sort_done) state_d = ST_COUNT;
			end
			ST_COUNT: state_d = ST_ENABLE;
			ST_ENABLE: begin
				if (st.en_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.exec = in_valid;
				ctl.sort_start = in_valid && st.is_pass;
			end
			ST_SORT: ctl.sort_step = 1'b1;
			ST_COUNT: begin
				ctl.count = 1'b1;
				ctl.en_start = 1'b1;
			end
			ST_ENABLE: ctl.en_step = 1'b1;
			ST_OUT: ctl.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
	assign out_valid = out_valid_q;

	`CSPS_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE, "ready outside idle")
	`CSPS_ASSERT_NXT(a_load_valid, clk, arst_n, ctl.out_load, out_valid_q, "load lost")
	`CSPS_ASSERT_IMP(a_no_overrun, clk, arst_n, out_valid_q && !out_ready, !ctl.out_load, "result overwritten")
endmodule

// ===== design/csps_dp.sv =====
// datapath of the charge slot scheduler: slot queue, sort unit, timers
// depends on csps_pkg
module csps_dp
	import csps_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [3:0]  cfg_data,
	input  logic [2:0]  cmd,
	input  logic [7:0]  channel,
	input  logic [31:0] seconds,
	input  logic        hard,
	input  logic [6:0]  soc,
	input  logic        present,
	input  logic        second_tick,
	input  ctrl_t       ctl,
	output stat_t       st,
	output logic        accepted,
	output logic [7:0]  power_mask,
	output logic [3:0]  active_count
);
	localparam int N = NUM_CHANNELS;
	localparam int IW = $clog2(N);
	localparam int CW = $clog2(N + 1);

	logic [3:0] max_q;
	logic [N-1:0] used_q, chg_q, hard_q, pres_q, pwr_q;
	logic [CW-1:0] chan_q [N];
	logic [31:0] secs_q [N];
	logic [6:0] soc_q [N];
	logic hang_q;
	logic [31:0] hang_secs_q;
	logic [3:0] last_q;
	logic tick_q, later_q, ok_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic [3:0] cnt_q;
	logic acc_q;
	logic [7:0] mask_q;
	logic [3:0] act_q;

	logic ch_ok;
	logic [IW-1:0] ch_idx;
	logic [IW-1:0] fslot;
	logic found;
	logic here;

	assign ch_ok = channel >= 8'd1 && channel <= 8'(N);
	assign ch_idx = IW'(channel - 8'd1);
	assign here = ch_ok && pres_q[ch_idx];

	always_comb begin
		fslot = '0;
		found = 1'b0;
		for (int k = 0; k < N; k++) begin
			if (!found && ch_ok && 8'(chan_q[k]) == channel) begin
				fslot = IW'(k);
				found = 1'b1;
			end
		end
	end

	function automatic logic [7:0] wgt(input logic u, input logic h, input logic [6:0] s,
		input logic lat);
		logic [7:0] w;
		w = 8'd0;
		if (u) begin
			if (h) w = lat ? 8'(HARD_LATER_WEIGHT) : 8'(HARD_FIRST_WEIGHT);
			else w = {s, 1'b0};
		end
		return w;
	endfunction

	logic [IW-1:0] ci, cj;
	logic hi, hj, swap;
	logic [7:0] wi, wj;
	assign ci = IW'(chan_q[i_q] - CW'(1));
	assign cj = IW'(chan_q[j_q] - CW'(1));
	assign hi = chan_q[i_q] >= CW'(1) && chan_q[i_q] <= CW'(N) && pres_q[ci];
	assign hj = chan_q[j_q] >= CW'(1) && chan_q[j_q] <= CW'(N) && pres_q[cj];
	assign wi = wgt(used_q[i_q], hard_q[i_q], soc_q[ci], later_q);
	assign wj = wgt(used_q[j_q], hard_q[j_q], soc_q[cj], later_q);
	assign swap = hi && hj && wi < wj;
	logic last_j;
	assign last_j = j_q == IW'(N - 1);
	assign st.sort_done = last_j && i_q == IW'(N - 2);
	assign st.is_pass = cmd == CMD_PASS;
	assign st.en_done = k_q == IW'(N - 1);

	logic [IW-1:0] ck;
	logic hk;
	assign ck = IW'(chan_q[k_q] - CW'(1));
	assign hk = chan_q[k_q] >= CW'(1) && chan_q[k_q] <= CW'(N) && pres_q[ck];

	logic [7:0] mask_full;
	always_comb begin
		mask_full = '0;
		for (int k = 0; k < N && k < 8; k++) mask_full[k] = pwr_q[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 4'(MAX_ACTIVE_RESET);
			used_q <= '0; chg_q <= '0; hard_q <= '0; pres_q <= '0; pwr_q <= '0;
			for (int k = 0; k < N; k++) begin
				chan_q[k] <= CW'(k + 1);
				secs_q[k] <= '0;
				soc_q[k] <= '0;
			end
			hang_q <= 1'b0;
			hang_secs_q <= '0;
			last_q <= '0;
		end else begin
			if (cfg_valid) max_q <= cfg_data;
			if (ctl.exec) begin
				unique case (cmd)
					CMD_UPDATE: if (ch_ok) begin
						soc_q[ch_idx] <= soc;
						pres_q[ch_idx] <= present;
					end
					CMD_ON: if (found) begin
						hard_q[fslot] <= hard;
						secs_q[fslot] <= seconds;
						used_q[fslot] <= 1'b1;
					end
					CMD_OFF: if (found) begin
						chg_q[fslot] <= 1'b0;
						hard_q[fslot] <= 1'b0;
						used_q[fslot] <= 1'b0;
						secs_q[fslot] <= '0;
						if (here) pwr_q[ch_idx] <= 1'b0;
					end
					CMD_HANGUP: if (found && here) begin
						used_q[fslot] <= 1'b0;
						pwr_q[ch_idx] <= 1'b0;
					end
					CMD_RECOVER: if (found && here) used_q[fslot] <= 1'b1;
					CMD_HANGALL: begin
						pwr_q <= pwr_q & ~pres_q;
						hang_q <= 1'b1;
						hang_secs_q <= seconds;
					end
					default: ;
				endcase
			end
			if (ctl.sort_step && swap) begin
				used_q[i_q] <= used_q[j_q]; used_q[j_q] <= used_q[i_q];
				chg_q[i_q] <= chg_q[j_q]; chg_q[j_q] <= chg_q[i_q];
				hard_q[i_q] <= hard_q[j_q]; hard_q[j_q] <= hard_q[i_q];
				chan_q[i_q] <= chan_q[j_q]; chan_q[j_q] <= chan_q[i_q];
				secs_q[i_q] <= secs_q[j_q]; secs_q[j_q] <= secs_q[i_q];
			end
			if (ctl.count) begin
				if (tick_q) begin
					if (!hang_q) begin
						for (int k = 0; k < N; k++)
							if (used_q[k] && chg_q[k]) begin
								if (secs_q[k] != 32'd0) secs_q[k] <= secs_q[k] - 32'd1;
								else used_q[k] <= 1'b0;
							end
					end else if (hang_secs_q != 32'd0) begin
						hang_secs_q <= hang_secs_q - 32'd1;
						if (hang_secs_q == 32'd1) hang_q <= 1'b0;
					end else hang_q <= 1'b0;
				end else if (hang_secs_q == 32'd0) hang_q <= 1'b0;
			end
			if (ctl.en_step) begin
				if (hk) begin
					if (used_q[k_q] && !hang_q && cnt_q < max_q) begin
						chg_q[k_q] <= 1'b1;
						pwr_q[ck] <= 1'b1;
					end else begin
						chg_q[k_q] <= 1'b0;
						pwr_q[ck] <= 1'b0;
					end
				end
				if (st.en_done) last_q <= cnt_q +
					4'(hk && used_q[k_q] && !hang_q && cnt_q < max_q);
			end
		end
	end

	// sequencing registers and output register
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			tick_q <= second_tick;
			unique case (cmd)
				CMD_UPDATE: ok_q <= ch_ok;
				CMD_ON: ok_q <= found;
				CMD_OFF, CMD_HANGUP, CMD_RECOVER: ok_q <= found && here;
				CMD_HANGALL, CMD_PASS: ok_q <= 1'b1;
				default: ok_q <= 1'b0;
			endcase
		end
		if (ctl.sort_start) begin
			i_q <= '0; j_q <= IW'(1); later_q <= 1'b0;
		end else if (ctl.sort_step) begin
			if (last_j) begin
				i_q <= i_q + IW'(1);
				j_q <= i_q + IW'(2);
				if (i_q == '0 ? (swap ? used_q[j_q] && hard_q[j_q] : used_q[0] && hard_q[0])
					: used_q[0] && hard_q[0]) later_q <= 1'b1;
			end else j_q <= j_q + IW'(1);
		end
		if (ctl.en_start) begin
			k_q <= '0; cnt_q <= '0;
		end else if (ctl.en_step) begin
			k_q <= k_q + IW'(1);
			if (hk && used_q[k_q] && !hang_q && cnt_q < max_q) cnt_q <= cnt_q + 4'd1;
		end
		if (ctl.out_load) begin
			acc_q <= ok_q;
			mask_q <= mask_full;
			act_q <= last_q;
		end
	end

	assign accepted = acc_q;
	assign power_mask = mask_q;
	assign active_count = act_q;
endmodule

// ===== design/charge_slot_priority_scheduler_core.sv =====
// Charge slot scheduler top level: joins controller and datapath.
// Depends on csps_pkg, csps_ctrl and csps_dp.
//
// Usage: one command item enters on in_valid/in_ready, one result item
// leaves on out_valid/out_ready per command. max_active is written on
// cfg_valid/cfg_ready (always ready); the user must do so only while
// the block is idle, which the block itself does not enforce.
// A non-pass command goes from ST_IDLE straight to ST_OUT, which loads
// its result register once any older result has been delivered.
// A pass runs N(N-1)/2 sort steps (one compare-exchange per cycle),
// a count-down step and N enable steps before ST_OUT loads the result.
// One item is processed at a time.
// Reset clears all slots, presence, power and timers; max_active is 2.
// A stalled receiver holds the result register; the next item may be
// taken meanwhile, but its result waits until the old one is delivered.
module charge_slot_priority_scheduler_core
	import csps_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [7:0]  channel,
	input  logic [31:0] seconds,
	input  logic        hard,
	input  logic [6:0]  soc,
	input  logic        present,
	input  logic        second_tick,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [7:0]  power_mask,
	output logic [3:0]  active_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	ctrl_t ctl;
	stat_t st;

	assign cfg_ready = 1'b1;

	csps_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .st, .ctl
	);

	csps_dp #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
		.clk, .arst_n, .cfg_valid, .cfg_data, .cmd, .channel, .seconds, .hard, .soc,
		.present, .second_tick, .ctl, .st, .accepted, .power_mask, .active_count
	);
endmodule
